/* rtl/tlsc_pkg.sv */
// Shared constants, types and a helper function for the tensor layout size calculator.
`timescale 1ns / 1ps

package tlsc_pkg;

    localparam int PACK_FACTOR = 4;

    localparam int H_W      = 12;
    localparam int W_W      = 12;
    localparam int CH_W     = 11;
    localparam int PAD_W    = 4;
    localparam int ELEM_W   = 3;
    localparam int ORD_W    = 2;
    localparam int BYTES_W  = 48;
    localparam int TOUT_W   = 9;

    localparam int TILE_W   = CH_W - $clog2(PACK_FACTOR) + 1;
    localparam int PADC_W   = CH_W + 1;
    localparam int EXT_W    = W_W + 1;
    localparam int SIZE_W   = 3;
    localparam int MUL_W    = BYTES_W / 2;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int SUM_W    = 3 * MUL_W;
    localparam int COST_W   = 2 * TILE_W + 1;
    localparam int CNT_W    = $clog2(TILE_W + 1);
    localparam int STEP_W   = 2;
    localparam int LAST_STEP = 2;

    typedef enum logic [ORD_W-1:0] {
        ORD_CHAN    = 2'd0,
        ORD_SHALLOW = 2'd1,
        ORD_DEEP    = 2'd2
    } order_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_EVAL,
        ST_PREP_W,
        ST_PREP_H,
        ST_MUL_LO,
        ST_MUL_HI
    } state_t;

    typedef struct packed {
        logic              start;
        logic [TILE_W-1:0] dividend;
        logic [TILE_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [TILE_W-1:0] quot;
        logic [TILE_W-1:0] rem;
    } div_res_t;

    function automatic logic [SIZE_W-1:0] elem_size(input logic [ELEM_W-1:0] code);
        logic [SIZE_W-1:0] sz;
        case (code)
            3'd0:    sz = 3'd4;
            3'd1:    sz = 3'd4;
            3'd2:    sz = 3'd2;
            3'd3:    sz = 3'd1;
            3'd4:    sz = 3'd4;
            3'd5:    sz = 3'd2;
            3'd6:    sz = 3'd1;
            default: sz = 3'd0;
        endcase
        return sz;
    endfunction

endpackage

/* rtl/tlsc_div.sv */
// Restoring divider that produces one quotient bit per cycle for the tiling search.
`timescale 1ns / 1ps

module tlsc_div import tlsc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_res_t res
);

    logic              run_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [TILE_W-1:0] dvs_reg;
    logic [TILE_W-1:0] rem_reg;
    logic [TILE_W-1:0] quo_reg;

    logic [TILE_W:0]   trial;
    logic              fits;
    logic [TILE_W-1:0] rem_next;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[TILE_W-1]};
        fits     = (trial >= {1'b0, dvs_reg});
        rem_next = fits ? TILE_W'(trial - {1'b0, dvs_reg}) : trial[TILE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            dvs_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
        end
        else if (req.start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(TILE_W);
            dvs_reg  <= req.divisor;
            rem_reg  <= '0;
            quo_reg  <= req.dividend;
        end
        else if (run_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[TILE_W-2:0], fits};
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign res.done = done_reg;
    assign res.quot = quo_reg;
    assign res.rem  = rem_reg;

endmodule

/* rtl/tensor_layout_size_calc.sv */
// Top level of the tensor layout size calculator with its sequencer and shared multiplier.
`timescale 1ns / 1ps

// A request is transferred at a rising edge where start is high and busy is low; the
// shape fields are sampled at that edge. busy stays high until the result is out.
// The result appears on byte_count, tile_cols, tile_rows and tiling_error for exactly
// one cycle, marked by done; the receiver cannot stall it, and the fields then hold
// until the next result. A new request may be issued in the cycle done is high.
// The tiling search visits row counts 1, 2, ... until the ceiling of tiles/rows no
// longer exceeds the row count. Each visited row count takes one run of the
// one-bit-per-cycle divider and an evaluation step. The byte count is then formed on
// the shared 24 x 24 multiplier: first the width and height extents, then a low and a
// high half product for each further factor. One request is in flight at a time.
// Reset clears the sequencer and the divider; the block is ready as soon as reset is
// released.

module tensor_layout_size_calc import tlsc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output logic               done,
    input  logic [H_W-1:0]     height,
    input  logic [W_W-1:0]     width,
    input  logic [CH_W-1:0]    channels,
    input  logic [PAD_W-1:0]   padding,
    input  logic [ELEM_W-1:0]  elem_type,
    input  logic [ORD_W-1:0]   stored_order,
    input  logic [ORD_W-1:0]   target_order,
    output logic [BYTES_W-1:0] byte_count,
    output logic [TOUT_W-1:0]  tile_cols,
    output logic [TOUT_W-1:0]  tile_rows,
    output logic               tiling_error
);

    state_t              state_reg, state_next;
    logic [TILE_W-1:0]   y_reg, y_next;
    logic [TILE_W-1:0]   x_reg, x_next;
    logic                have_reg, have_next;
    logic [COST_W-1:0]   best_reg, best_next;
    logic [TILE_W-1:0]   bx_reg, bx_next;
    logic [TILE_W-1:0]   by_reg, by_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                sat_reg, sat_next;
    logic                done_reg, done_next;
    logic [H_W-1:0]      h_reg, h_next;
    logic [W_W-1:0]      w_reg, w_next;
    logic [CH_W-1:0]     c_reg, c_next;
    logic [PAD_W-1:0]    pad_reg, pad_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    order_t              so_reg, so_next;
    order_t              to_reg, to_next;
    logic [TILE_W-1:0]   tiles_reg, tiles_next;
    logic [BYTES_W-1:0]  acc_reg, acc_next;
    logic [PROD_W-1:0]   lo_reg, lo_next;
    logic [MUL_W-1:0]    fac_reg, fac_next;
    logic [BYTES_W-1:0]  bytes_reg, bytes_next;
    logic [TOUT_W-1:0]   cols_reg, cols_next;
    logic [TOUT_W-1:0]   rows_reg, rows_next;
    logic                err_reg, err_next;

    logic [MUL_W-1:0]    mul_a;
    logic [MUL_W-1:0]    mul_b;
    logic [PROD_W-1:0]   mul_p;
    div_req_t            div_req;
    div_res_t            div_res;

    logic [TILE_W-1:0]   tiles_in;
    order_t              so_in;
    order_t              to_in;
    logic [TILE_W-1:0]   xe;
    logic [COST_W-1:0]   cost;
    logic                stop;
    logic [EXT_W-1:0]    term;
    logic [EXT_W-1:0]    add_term;
    logic [TILE_W-1:0]   mult_sel;
    logic [SUM_W-1:0]    sum;
    logic [PADC_W-1:0]   padc;
    logic [MUL_W-1:0]    fac_step;
    logic                size_ok;

    tlsc_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .res   (div_res)
    );

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        tiles_in = TILE_W'(({1'b0, channels} + PADC_W'(PACK_FACTOR - 1))
                           / PADC_W'(PACK_FACTOR));
        if (stored_order == ORD_SHALLOW || stored_order == ORD_DEEP)
        begin
            so_in = order_t'(stored_order);
        end
        else
        begin
            so_in = ORD_CHAN;
        end
        if (target_order == ORD_CHAN || target_order == ORD_SHALLOW
            || target_order == ORD_DEEP)
        begin
            to_in = order_t'(target_order);
        end
        else
        begin
            to_in = so_in;
        end

        xe   = (x_reg < y_reg) ? y_reg : x_reg;
        stop = (x_reg <= y_reg) || (y_reg == tiles_reg);
        padc = PADC_W'(tiles_reg) * PADC_W'(PACK_FACTOR);
        sum  = {mul_p, {MUL_W{1'b0}}} + SUM_W'(lo_reg);

        size_ok = (c_reg != '0) && (w_reg != '0 || pad_reg != '0)
                  && (h_reg != '0 || pad_reg != '0) && (size_reg != '0);

        unique case (to_reg)
            ORD_CHAN:    fac_step = MUL_W'(c_reg);
            ORD_SHALLOW: fac_step = MUL_W'(padc);
            ORD_DEEP:    fac_step = MUL_W'(PACK_FACTOR);
            default:     fac_step = MUL_W'(c_reg);
        endcase

        // Extent terms for the width pass, the height pass reuses the same shape.
        if (to_reg == ORD_DEEP)
        begin
            mult_sel = (state_reg == ST_PREP_H) ? by_reg : bx_reg;
            if (so_reg == ORD_DEEP)
            begin
                term     = (state_reg == ST_PREP_H) ? EXT_W'(h_reg) : EXT_W'(w_reg);
                add_term = EXT_W'({pad_reg, 1'b0});
            end
            else
            begin
                term     = (state_reg == ST_PREP_H) ? EXT_W'(h_reg) + EXT_W'(pad_reg)
                                                    : EXT_W'(w_reg) + EXT_W'(pad_reg);
                add_term = EXT_W'(pad_reg);
            end
        end
        else
        begin
            mult_sel = TILE_W'(1);
            term     = (state_reg == ST_PREP_H) ? EXT_W'(h_reg) + EXT_W'({pad_reg, 1'b0})
                                                : EXT_W'(w_reg) + EXT_W'({pad_reg, 1'b0});
            add_term = '0;
        end

        cost = COST_W'(xe) - COST_W'(y_reg) + mul_p[COST_W-1:0] - COST_W'(tiles_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        y_next     = y_reg;
        x_next     = x_reg;
        have_next  = have_reg;
        best_next  = best_reg;
        bx_next    = bx_reg;
        by_next    = by_reg;
        step_next  = step_reg;
        sat_next   = sat_reg;
        done_next  = 1'b0;
        h_next     = h_reg;
        w_next     = w_reg;
        c_next     = c_reg;
        pad_next   = pad_reg;
        size_next  = size_reg;
        so_next    = so_reg;
        to_next    = to_reg;
        tiles_next = tiles_reg;
        acc_next   = acc_reg;
        lo_next    = lo_reg;
        fac_next   = fac_reg;
        bytes_next = bytes_reg;
        cols_next  = cols_reg;
        rows_next  = rows_reg;
        err_next   = err_reg;

        mul_a = '0;
        mul_b = '0;

        div_req.start    = 1'b0;
        div_req.dividend = tiles_reg;
        div_req.divisor  = y_reg + TILE_W'(1);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    h_next     = height;
                    w_next     = width;
                    c_next     = channels;
                    pad_next   = padding;
                    size_next  = elem_size(elem_type);
                    so_next    = so_in;
                    to_next    = to_in;
                    tiles_next = tiles_in;
                    y_next     = TILE_W'(1);
                    have_next  = 1'b0;
                    best_next  = '0;
                    bx_next    = '0;
                    by_next    = '0;
                    sat_next   = 1'b0;
                    if (tiles_in == '0)
                    begin
                        state_next = ST_PREP_W;
                    end
                    else
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = tiles_in;
                        div_req.divisor  = TILE_W'(1);
                        state_next       = ST_DIV;
                    end
                end
            end

            ST_DIV:
            begin
                if (div_res.done)
                begin
                    x_next     = div_res.quot + TILE_W'(div_res.rem != '0);
                    state_next = ST_EVAL;
                end
            end

            ST_EVAL:
            begin
                mul_a = MUL_W'(xe);
                mul_b = MUL_W'(y_reg);
                if (!have_reg || cost < best_reg)
                begin
                    have_next = 1'b1;
                    best_next = cost;
                    bx_next   = xe;
                    by_next   = y_reg;
                end
                if (stop)
                begin
                    state_next = ST_PREP_W;
                end
                else
                begin
                    y_next        = y_reg + TILE_W'(1);
                    div_req.start = 1'b1;
                    state_next    = ST_DIV;
                end
            end

            ST_PREP_W:
            begin
                mul_a      = MUL_W'(mult_sel);
                mul_b      = MUL_W'(term);
                acc_next   = BYTES_W'(mul_p) + BYTES_W'(add_term);
                state_next = ST_PREP_H;
            end

            ST_PREP_H:
            begin
                mul_a      = MUL_W'(mult_sel);
                mul_b      = MUL_W'(term);
                fac_next   = MUL_W'(mul_p + PROD_W'(add_term));
                step_next  = '0;
                state_next = ST_MUL_LO;
            end

            ST_MUL_LO:
            begin
                mul_a      = acc_reg[MUL_W-1:0];
                mul_b      = fac_reg;
                lo_next    = mul_p;
                state_next = ST_MUL_HI;
            end

            ST_MUL_HI:
            begin
                mul_a    = acc_reg[BYTES_W-1:MUL_W];
                mul_b    = fac_reg;
                acc_next = sum[BYTES_W-1:0];
                sat_next = sat_reg | (sum[SUM_W-1:BYTES_W] != '0);
                if (step_reg == STEP_W'(LAST_STEP))
                begin
                    if (!size_ok)
                    begin
                        bytes_next = '0;
                    end
                    else if (sat_next)
                    begin
                        bytes_next = '1;
                    end
                    else
                    begin
                        bytes_next = sum[BYTES_W-1:0];
                    end
                    cols_next  = bx_reg[TOUT_W-1:0];
                    rows_next  = by_reg[TOUT_W-1:0];
                    err_next   = (so_reg == ORD_DEEP) && (c_reg == '0);
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    fac_next   = (step_reg == '0) ? fac_step : MUL_W'(size_reg);
                    step_next  = step_reg + STEP_W'(1);
                    state_next = ST_MUL_LO;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            sat_reg   <= 1'b0;
            done_reg  <= 1'b0;
            have_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            sat_reg   <= sat_next;
            done_reg  <= done_next;
            have_reg  <= have_next;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg     <= y_next;
        x_reg     <= x_next;
        best_reg  <= best_next;
        bx_reg    <= bx_next;
        by_reg    <= by_next;
        h_reg     <= h_next;
        w_reg     <= w_next;
        c_reg     <= c_next;
        pad_reg   <= pad_next;
        size_reg  <= size_next;
        so_reg    <= so_next;
        to_reg    <= to_next;
        tiles_reg <= tiles_next;
        acc_reg   <= acc_next;
        lo_reg    <= lo_next;
        fac_reg   <= fac_next;
        bytes_reg <= bytes_next;
        cols_reg  <= cols_next;
        rows_reg  <= rows_next;
        err_reg   <= err_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign byte_count   = bytes_reg;
    assign tile_cols    = cols_reg;
    assign tile_rows    = rows_reg;
    assign tiling_error = err_reg;

endmodule
